// ===== rtl/http_request_head_parser_assert.svh =====
// Assertion macros used by the request head parser top level.
`ifndef HTTP_REQUEST_HEAD_PARSER_ASSERT_SVH
`define HTTP_REQUEST_HEAD_PARSER_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define HRHP_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define HRHP_ASSERT_NEXT(name, trig, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== rtl/hrhp_pkg.sv =====
// Types, codes and helper functions of the HTTP request head parser.
`timescale 1ns / 1ps

package hrhp_pkg;

    localparam logic [7:0] ASCII_NUL   = 8'h00;
    localparam logic [7:0] ASCII_LF    = 8'h0A;
    localparam logic [7:0] ASCII_CR    = 8'h0D;
    localparam logic [7:0] ASCII_SP    = 8'h20;
    localparam logic [7:0] ASCII_SLASH = 8'h2F;
    localparam logic [7:0] ASCII_DOT   = 8'h2E;
    localparam logic [7:0] ASCII_COLON = 8'h3A;
    localparam logic [7:0] ASCII_0     = 8'h30;
    localparam logic [7:0] ASCII_1     = 8'h31;
    localparam logic [7:0] ASCII_9     = 8'h39;
    localparam logic [7:0] ASCII_A     = 8'h41;
    localparam logic [7:0] ASCII_Z     = 8'h5A;
    localparam logic [7:0] ASCII_H     = 8'h48;
    localparam logic [7:0] ASCII_T     = 8'h54;
    localparam logic [7:0] ASCII_P     = 8'h50;

    localparam int unsigned NUM_W     = 10;
    localparam int unsigned VER_W     = 20;
    localparam logic [NUM_W-1:0] DIGIT_LIMIT   = 10'd999;
    localparam logic [NUM_W-1:0] MISSING_MINOR = 10'd9;
    localparam logic [VER_W-1:0] VERSION_SCALE = 20'd1000;

    typedef enum logic [4:0] {
        PH_R_START      = 5'd0,
        PH_R_METHOD     = 5'd1,
        PH_R_SP_URI     = 5'd2,
        PH_R_URI        = 5'd3,
        PH_R_HTTP09     = 5'd4,
        PH_R_H          = 5'd5,
        PH_R_HT         = 5'd6,
        PH_R_HTT        = 5'd7,
        PH_R_HTTP       = 5'd8,
        PH_R_MAJ1       = 5'd9,
        PH_R_MAJ        = 5'd10,
        PH_R_MIN1       = 5'd11,
        PH_R_MIN        = 5'd12,
        PH_R_SP_AFTER   = 5'd13,
        PH_R_ALMOST     = 5'd14,
        PH_H_START      = 5'd15,
        PH_H_NAME       = 5'd16,
        PH_H_SP_BEFORE  = 5'd17,
        PH_H_VALUE      = 5'd18,
        PH_H_SP_AFTER   = 5'd19,
        PH_H_ALMOST     = 5'd20,
        PH_H_END_ALMOST = 5'd21,
        PH_DONE         = 5'd22,
        PH_DEAD         = 5'd23
    } t_phase;

    typedef enum logic [2:0] {
        ROLE_NONE      = 3'd0,
        ROLE_METHOD    = 3'd1,
        ROLE_URI       = 3'd2,
        ROLE_URI_SP    = 3'd3,
        ROLE_HDR_NAME  = 3'd4,
        ROLE_HDR_VALUE = 3'd5,
        ROLE_VALUE_SP  = 3'd6
    } t_role;

    typedef enum logic [3:0] {
        EV_NONE       = 4'd0,
        EV_METHOD     = 4'd1,
        EV_LINE_OK    = 4'd2,
        EV_STORED     = 4'd3,
        EV_DROPPED    = 4'd4,
        EV_HDRS_DONE  = 4'd5,
        EV_BAD_REQ    = 4'd6,
        EV_BAD_HDR    = 4'd7,
        EV_INCOMPLETE = 4'd8
    } t_event;

    // Per-byte verdict handed from the parser core to the output register.
    typedef struct packed {
        logic [VER_W-1:0] version;
        t_event           event_code;
        t_role            role;
    } t_result;

    function automatic logic is_upper(input logic [7:0] b);
        return (b >= ASCII_A) && (b <= ASCII_Z);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= ASCII_0) && (b <= ASCII_9);
    endfunction

    // Append one decimal digit, saturating at the limit.
    function automatic logic [NUM_W-1:0] add_digit(input logic [NUM_W-1:0] cur,
                                                   input logic [3:0] d);
        logic [13:0] v;
        v = 14'(cur) * 14'd10 + 14'(d);
        return (v > 14'(DIGIT_LIMIT)) ? DIGIT_LIMIT : v[NUM_W-1:0];
    endfunction

endpackage

// ===== rtl/http_request_head_parser.sv =====
// A byte accepted into the input register is classified by the core and moved into the
// result register once that is free or draining. Throughput: one byte per cycle while
// results are taken, set by the single-pass parser between input and result registers;
// while a result waits downstream the input register takes one byte, then stalls.
// Reset (synchronous, active low): both pipeline stages empty, parser at request line start.
`timescale 1ns / 1ps
`include "http_request_head_parser_assert.svh"

module http_request_head_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic        s_axis_tlast,   // end_of_packet
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] echo_byte, [27:8] http_version, [31:28] zero
    output logic [6:0]  m_axis_tuser    // [2:0] byte_role, [6:3] event_code
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    hrhp_pkg::t_result r_out;
    hrhp_pkg::t_result w_result;
    logic              w_advance;
    logic              w_version_ok;
    logic              w_token_ok;

    // Move a byte into the result register when that register is free or draining
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    hrhp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_byte   (r_in_byte),
        .i_eop    (r_in_last),
        .o_result (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_byte <= r_in_byte;
            r_out      <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.version, r_out_byte};
    assign m_axis_tuser  = {r_out.event_code, r_out.role};

    // Checked properties of the held result
    assign w_version_ok = (r_out.version == '0) || (r_out.event_code == hrhp_pkg::EV_LINE_OK);
    assign w_token_ok   = (r_out.role == hrhp_pkg::ROLE_NONE)
                       || (r_out.event_code == hrhp_pkg::EV_NONE)
                       || (r_out.event_code == hrhp_pkg::EV_INCOMPLETE);

    `HRHP_ASSERT_NEXT(a_advance_fills_out, w_advance, r_out_valid, "advanced byte lost")
    `HRHP_ASSERT_NEXT(a_in_held_on_stall, r_in_valid && !w_advance, r_in_valid, "stalled byte lost")
    `HRHP_ASSERT_ALWAYS(a_version_only_line_ok, !r_out_valid || w_version_ok, "stray version")
    `HRHP_ASSERT_ALWAYS(a_token_no_event, !r_out_valid || w_token_ok, "token byte with event")

endmodule

// ===== rtl/hrhp_core.sv =====
// Parser state machine: classifies one byte per step and tracks the version.
`timescale 1ns / 1ps

module hrhp_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    input  logic                i_eop,
    output hrhp_pkg::t_result   o_result
);

    hrhp_pkg::t_phase            r_phase, n_phase;
    logic [hrhp_pkg::NUM_W-1:0]  r_major, n_major;
    logic [hrhp_pkg::NUM_W-1:0]  r_minor, n_minor;
    logic                        r_value_present, n_value_present;

    hrhp_pkg::t_phase            w_phase;
    hrhp_pkg::t_role             w_role;
    hrhp_pkg::t_event            w_event;
    logic [3:0]                  w_digit;

    assign w_digit = i_byte[3:0];

    // Next state of the parse machine for the current byte
    always_comb begin
        w_phase         = r_phase;
        n_major         = r_major;
        n_minor         = r_minor;
        n_value_present = r_value_present;
        w_event         = hrhp_pkg::EV_NONE;
        unique case (r_phase)
            hrhp_pkg::PH_R_START: begin
                if (hrhp_pkg::is_upper(i_byte)) begin
                    w_phase = hrhp_pkg::PH_R_METHOD;
                end else begin
                    w_event = hrhp_pkg::EV_BAD_REQ;
                    w_phase = hrhp_pkg::PH_DEAD;
                end
            end
            hrhp_pkg::PH_R_METHOD: begin
                if (i_byte == hrhp_pkg::ASCII_SP) begin
                    w_event = hrhp_pkg::EV_METHOD;
                    w_phase = hrhp_pkg::PH_R_SP_URI;
                end else if (!hrhp_pkg::is_upper(i_byte)) begin
                    w_event = hrhp_pkg::EV_BAD_REQ;
                    w_phase = hrhp_pkg::PH_DEAD;
                end
            end
            hrhp_pkg::PH_R_SP_URI: begin
                if (i_byte != hrhp_pkg::ASCII_SP) begin
                    w_phase = hrhp_pkg::PH_R_URI;
                end
            end
            hrhp_pkg::PH_R_URI, hrhp_pkg::PH_R_HTTP09: begin
                priority if (i_byte == hrhp_pkg::ASCII_SP) begin
                    w_phase = hrhp_pkg::PH_R_HTTP09;
                end else if (i_byte == hrhp_pkg::ASCII_CR) begin
                    n_minor = hrhp_pkg::MISSING_MINOR;
                    w_phase = hrhp_pkg::PH_R_ALMOST;
                end else if (i_byte == hrhp_pkg::ASCII_LF) begin
                    n_minor = hrhp_pkg::MISSING_MINOR;
                    w_event = hrhp_pkg::EV_LINE_OK;
                    w_phase = hrhp_pkg::PH_H_START;
                end else if (r_phase == hrhp_pkg::PH_R_URI && i_byte == hrhp_pkg::ASCII_NUL) begin
                    w_event = hrhp_pkg::EV_BAD_REQ;
                    w_phase = hrhp_pkg::PH_DEAD;
                end else if (r_phase == hrhp_pkg::PH_R_HTTP09 && i_byte == hrhp_pkg::ASCII_H) begin
                    w_phase = hrhp_pkg::PH_R_H;
                end else begin
                    w_phase = hrhp_pkg::PH_R_URI;
                end
            end
            hrhp_pkg::PH_R_H: begin
                if (i_byte == hrhp_pkg::ASCII_T) begin
                    w_phase = hrhp_pkg::PH_R_HT;
                end else begin
                    w_event = hrhp_pkg::EV_BAD_REQ;
                    w_phase = hrhp_pkg::PH_DEAD;
                end
            end
            hrhp_pkg::PH_R_HT: begin
                if (i_byte == hrhp_pkg::ASCII_T) begin
                    w_phase = hrhp_pkg::PH_R_HTT;
                end else begin
                    w_event = hrhp_pkg::EV_BAD_REQ;
                    w_phase = hrhp_pkg::PH_DEAD;
                end
            end
            hrhp_pkg::PH_R_HTT: begin
                if (i_byte == hrhp_pkg::ASCII_P) begin
                    w_phase = hrhp_pkg::PH_R_HTTP;
                end else begin
                    w_event = hrhp_pkg::EV_BAD_REQ;
                    w_phase = hrhp_pkg::PH_DEAD;
                end
            end
            hrhp_pkg::PH_R_HTTP: begin
                if (i_byte == hrhp_pkg::ASCII_SLASH) begin
                    w_phase = hrhp_pkg::PH_R_MAJ1;
                end else begin
                    w_event = hrhp_pkg::EV_BAD_REQ;
                    w_phase = hrhp_pkg::PH_DEAD;
                end
            end
            hrhp_pkg::PH_R_MAJ1: begin
                if (i_byte >= hrhp_pkg::ASCII_1 && i_byte <= hrhp_pkg::ASCII_9) begin
                    n_major = hrhp_pkg::NUM_W'(w_digit);
                    w_phase = hrhp_pkg::PH_R_MAJ;
                end else begin
                    w_event = hrhp_pkg::EV_BAD_REQ;
                    w_phase = hrhp_pkg::PH_DEAD;
                end
            end
            hrhp_pkg::PH_R_MAJ: begin
                if (i_byte == hrhp_pkg::ASCII_DOT) begin
                    w_phase = hrhp_pkg::PH_R_MIN1;
                end else if (hrhp_pkg::is_digit(i_byte)) begin
                    n_major = hrhp_pkg::add_digit(r_major, w_digit);
                end else begin
                    w_event = hrhp_pkg::EV_BAD_REQ;
                    w_phase = hrhp_pkg::PH_DEAD;
                end
            end
            hrhp_pkg::PH_R_MIN1: begin
                if (hrhp_pkg::is_digit(i_byte)) begin
                    n_minor = hrhp_pkg::NUM_W'(w_digit);
                    w_phase = hrhp_pkg::PH_R_MIN;
                end else begin
                    w_event = hrhp_pkg::EV_BAD_REQ;
                    w_phase = hrhp_pkg::PH_DEAD;
                end
            end
            hrhp_pkg::PH_R_MIN: begin
                priority if (i_byte == hrhp_pkg::ASCII_CR) begin
                    w_phase = hrhp_pkg::PH_R_ALMOST;
                end else if (i_byte == hrhp_pkg::ASCII_LF) begin
                    w_event = hrhp_pkg::EV_LINE_OK;
                    w_phase = hrhp_pkg::PH_H_START;
                end else if (i_byte == hrhp_pkg::ASCII_SP) begin
                    w_phase = hrhp_pkg::PH_R_SP_AFTER;
                end else if (hrhp_pkg::is_digit(i_byte)) begin
                    n_minor = hrhp_pkg::add_digit(r_minor, w_digit);
                end else begin
                    w_event = hrhp_pkg::EV_BAD_REQ;
                    w_phase = hrhp_pkg::PH_DEAD;
                end
            end
            hrhp_pkg::PH_R_SP_AFTER: begin
                priority if (i_byte == hrhp_pkg::ASCII_SP) begin
                    w_phase = hrhp_pkg::PH_R_SP_AFTER;
                end else if (i_byte == hrhp_pkg::ASCII_CR) begin
                    w_phase = hrhp_pkg::PH_R_ALMOST;
                end else if (i_byte == hrhp_pkg::ASCII_LF) begin
                    w_event = hrhp_pkg::EV_LINE_OK;
                    w_phase = hrhp_pkg::PH_H_START;
                end else begin
                    w_event = hrhp_pkg::EV_BAD_REQ;
                    w_phase = hrhp_pkg::PH_DEAD;
                end
            end
            hrhp_pkg::PH_R_ALMOST: begin
                if (i_byte == hrhp_pkg::ASCII_LF) begin
                    w_event = hrhp_pkg::EV_LINE_OK;
                    w_phase = hrhp_pkg::PH_H_START;
                end else begin
                    w_event = hrhp_pkg::EV_BAD_REQ;
                    w_phase = hrhp_pkg::PH_DEAD;
                end
            end
            hrhp_pkg::PH_H_START: begin
                n_value_present = 1'b0;
                priority if (i_byte == hrhp_pkg::ASCII_CR) begin
                    w_phase = hrhp_pkg::PH_H_END_ALMOST;
                end else if (i_byte == hrhp_pkg::ASCII_LF) begin
                    w_event = hrhp_pkg::EV_HDRS_DONE;
                    w_phase = hrhp_pkg::PH_DONE;
                end else begin
                    w_phase = hrhp_pkg::PH_H_NAME;
                end
            end
            hrhp_pkg::PH_H_NAME: begin
                priority if (i_byte == hrhp_pkg::ASCII_COLON) begin
                    w_phase = hrhp_pkg::PH_H_SP_BEFORE;
                end else if (i_byte == hrhp_pkg::ASCII_CR) begin
                    w_phase = hrhp_pkg::PH_H_ALMOST;
                end else if (i_byte == hrhp_pkg::ASCII_LF) begin
                    w_event = hrhp_pkg::EV_DROPPED;
                    w_phase = hrhp_pkg::PH_H_START;
                end else begin
                    w_phase = hrhp_pkg::PH_H_NAME;
                end
            end
            hrhp_pkg::PH_H_SP_BEFORE, hrhp_pkg::PH_H_VALUE, hrhp_pkg::PH_H_SP_AFTER: begin
                priority if (i_byte == hrhp_pkg::ASCII_SP) begin
                    if (r_phase != hrhp_pkg::PH_H_SP_BEFORE) begin
                        w_phase = hrhp_pkg::PH_H_SP_AFTER;
                    end
                end else if (i_byte == hrhp_pkg::ASCII_CR) begin
                    w_phase = hrhp_pkg::PH_H_ALMOST;
                end else if (i_byte == hrhp_pkg::ASCII_LF) begin
                    w_event = hrhp_pkg::EV_DROPPED;
                    w_phase = hrhp_pkg::PH_H_START;
                end else if (i_byte == hrhp_pkg::ASCII_NUL) begin
                    w_event = hrhp_pkg::EV_BAD_HDR;
                    w_phase = hrhp_pkg::PH_DEAD;
                end else begin
                    n_value_present = 1'b1;
                    w_phase         = hrhp_pkg::PH_H_VALUE;
                end
            end
            hrhp_pkg::PH_H_ALMOST: begin
                if (i_byte == hrhp_pkg::ASCII_LF) begin
                    w_event = r_value_present ? hrhp_pkg::EV_STORED : hrhp_pkg::EV_DROPPED;
                    w_phase = hrhp_pkg::PH_H_START;
                end else if (i_byte != hrhp_pkg::ASCII_CR) begin
                    w_event = hrhp_pkg::EV_BAD_HDR;
                    w_phase = hrhp_pkg::PH_DEAD;
                end
            end
            hrhp_pkg::PH_H_END_ALMOST: begin
                if (i_byte == hrhp_pkg::ASCII_LF) begin
                    w_event = hrhp_pkg::EV_HDRS_DONE;
                    w_phase = hrhp_pkg::PH_DONE;
                end else if (i_byte != hrhp_pkg::ASCII_CR) begin
                    w_event = hrhp_pkg::EV_BAD_HDR;
                    w_phase = hrhp_pkg::PH_DEAD;
                end
            end
            default: begin
                // Head finished or rejected: ignore bytes until packet end
                w_phase = r_phase;
            end
        endcase

        // Packet end rewinds to the request line
        n_phase = w_phase;
        if (i_eop) begin
            n_phase         = hrhp_pkg::PH_R_START;
            n_major         = '0;
            n_minor         = '0;
            n_value_present = 1'b0;
        end
    end

    // Byte role: token bytes carry their token class, syntax bytes none
    always_comb begin
        w_role = hrhp_pkg::ROLE_NONE;
        unique case (r_phase)
            hrhp_pkg::PH_R_START, hrhp_pkg::PH_R_METHOD: begin
                if (hrhp_pkg::is_upper(i_byte)) begin
                    w_role = hrhp_pkg::ROLE_METHOD;
                end
            end
            hrhp_pkg::PH_R_SP_URI: begin
                if (i_byte != hrhp_pkg::ASCII_SP) begin
                    w_role = hrhp_pkg::ROLE_URI;
                end
            end
            hrhp_pkg::PH_R_URI, hrhp_pkg::PH_R_HTTP09: begin
                if (w_phase == hrhp_pkg::PH_R_HTTP09) begin
                    w_role = hrhp_pkg::ROLE_URI_SP;
                end else if (w_phase == hrhp_pkg::PH_R_URI) begin
                    w_role = hrhp_pkg::ROLE_URI;
                end
            end
            hrhp_pkg::PH_H_START, hrhp_pkg::PH_H_NAME: begin
                if (w_phase == hrhp_pkg::PH_H_NAME) begin
                    w_role = hrhp_pkg::ROLE_HDR_NAME;
                end
            end
            hrhp_pkg::PH_H_SP_BEFORE, hrhp_pkg::PH_H_VALUE, hrhp_pkg::PH_H_SP_AFTER: begin
                if (w_phase == hrhp_pkg::PH_H_SP_AFTER) begin
                    w_role = hrhp_pkg::ROLE_VALUE_SP;
                end else if (w_phase == hrhp_pkg::PH_H_VALUE) begin
                    w_role = hrhp_pkg::ROLE_HDR_VALUE;
                end
            end
            default: begin
                w_role = hrhp_pkg::ROLE_NONE;
            end
        endcase
    end

    // Event and version; an unfinished head at packet end overrides the event
    always_comb begin
        o_result.role       = w_role;
        o_result.event_code = w_event;
        o_result.version    = '0;
        if (w_event == hrhp_pkg::EV_LINE_OK) begin
            o_result.version = hrhp_pkg::VER_W'(r_major) * hrhp_pkg::VERSION_SCALE
                             + hrhp_pkg::VER_W'(n_minor);
        end
        if (i_eop && w_phase != hrhp_pkg::PH_DONE && w_phase != hrhp_pkg::PH_DEAD) begin
            o_result.event_code = hrhp_pkg::EV_INCOMPLETE;
            o_result.version    = '0;
        end
    end

    // Commit state on each processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= hrhp_pkg::PH_R_START;
            r_major         <= '0;
            r_minor         <= '0;
            r_value_present <= 1'b0;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_major         <= n_major;
            r_minor         <= n_minor;
            r_value_present <= n_value_present;
        end
    end

endmodule
